// ===== sv/sdinit_pkg.sv =====
// Package: phase encoding, result and error codes for the SD init sequencer.
package sdinit_pkg;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD0, PH_CMD8, PH_P55, PH_A41, PH_CMD2, PH_CMD3,
        PH_CMD9, PH_CMD7, PH_CMD16, PH_B55, PH_A6, PH_HOST
    } phase_t;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_OK    = 2'd1;
    localparam logic [1:0] OP_FAIL  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] RK_CMD  = 2'd0;
    localparam logic [1:0] RK_HOST = 2'd1;
    localparam logic [1:0] RK_DONE = 2'd2;
    localparam logic [1:0] RK_FAIL = 2'd3;

    localparam logic [2:0] RT_NONE = 3'd0;
    localparam logic [2:0] RT_R1   = 3'd1;
    localparam logic [2:0] RT_R1B  = 3'd2;
    localparam logic [2:0] RT_R2   = 3'd3;
    localparam logic [2:0] RT_R3   = 3'd4;
    localparam logic [2:0] RT_R6R7 = 3'd5;

    localparam logic [3:0] ERR_NONE   = 4'd0;
    localparam logic [3:0] ERR_NOCARD = 4'd1;
    localparam logic [3:0] ERR_CMD0   = 4'd2;
    localparam logic [3:0] ERR_ECHO   = 4'd3;
    localparam logic [3:0] ERR_A41    = 4'd4;
    localparam logic [3:0] ERR_TMO    = 4'd5;
    localparam logic [3:0] ERR_CMD2   = 4'd6;
    localparam logic [3:0] ERR_CMD3   = 4'd7;
    localparam logic [3:0] ERR_CMD9   = 4'd8;
    localparam logic [3:0] ERR_CMD7   = 4'd9;
    localparam logic [3:0] ERR_CMD16  = 4'd10;
    localparam logic [3:0] ERR_BUS    = 4'd11;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRY   = 2'd1;
    localparam logic [1:0] REG_OCR     = 2'd2;
    localparam logic [1:0] REG_BLKLEN  = 2'd3;

    localparam logic [32:0] SDHC_MAX_BLOCKS = 33'd67108864;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  index;
        logic [31:0] arg;
        logic [2:0]  rtype;
        logic [3:0]  err;
        logic [1:0]  ctype;
        logic [32:0] cap;
        logic [15:0] rca;
        logic [7:0]  mfr;
        logic [31:0] serial;
        logic [11:0] year;
        logic [3:0]  month;
    } result_t;

endpackage

// ===== sv/sdinit_csd.sv =====
// CSD capacity decode (v1 and v2 layouts) into 512-byte blocks.
module sdinit_csd (
    input  logic [31:0] w1,
    input  logic [31:0] w2,
    input  logic [31:0] w3,
    output logic [32:0] blocks
);
    logic [11:0] c_size;
    logic [2:0]  mult;
    logic [3:0]  bl;
    logic [5:0]  sh;
    logic [63:0] bytes;

    always_comb
    begin
        c_size = {w2[1:0], w1[31:22]};
        mult   = w1[9:7];
        bl     = w2[11:8];
        sh     = 6'(mult) + 6'd2 + 6'(bl);
        bytes  = (64'(c_size) + 64'd1) << sh;
        if (w3[23:22] == 2'd0)
        begin
            blocks = bytes[41:9];
        end
        else
        begin
            blocks = {1'b0, (32'(w1[29:8]) + 32'd1)} << 10;
        end
    end
endmodule

// ===== sv/sd_card_init_sequencer.sv =====
// Top level: SD card identification sequencer.
// A result word is registered and appears in the cycle after its event word is accepted.
// Throughput: one event word per cycle; each event updates state in one pass.
// The output register holds a result under stall; input accepted unless the
// output register is full and stalled.
// Reset (rst_n low, async) returns to idle, clears card state, loads register defaults.
module sd_card_init_sequencer #(
    parameter int POLL_COUNTER_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic        card_present,
    input  logic [31:0] resp_word0,
    input  logic [31:0] resp_word1,
    input  logic [31:0] resp_word2,
    input  logic [31:0] resp_word3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [5:0]  cmd_index,
    output logic [31:0] cmd_arg,
    output logic [2:0]  resp_type,
    output logic [3:0]  error_code,
    output logic [1:0]  card_type,
    output logic [32:0] card_blocks,
    output logic [15:0] card_address,
    output logic [7:0]  maker_code,
    output logic [31:0] card_serial,
    output logic [11:0] made_year,
    output logic [3:0]  made_month,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sdinit_pkg::*;

    // Configuration registers
    logic [23:0] timeout_reg;
    logic [2:0]  retry_reg;
    logic [23:0] ocr_reg;
    logic [11:0] blklen_reg;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic [2:0]  attempt_reg, attempt_next;
    logic        v2_reg, v2_next;
    logic        hc_reg, hc_next;
    logic [15:0] rca_reg, rca_next;
    logic [POLL_COUNTER_BITS-1:0] ticks_reg, ticks_next;
    logic [32:0] cap_reg, cap_next;
    logic [7:0]  mfr_reg, mfr_next;
    logic [31:0] serial_reg, serial_next;
    logic [11:0] date_reg, date_next;

    // Output register
    logic        ovalid_reg;
    result_t     res_reg, res_next;
    logic        emit;

    logic        accept;
    logic        ok;
    logic [32:0] csd_blocks;
    logic [31:0] rca_arg;
    logic        timed_out;
    logic        zero_timeout;

    assign cfg_ready = 1'b1;
    assign in_stall  = ovalid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign ok        = (opcode == OP_OK);
    assign rca_arg   = {rca_reg, 16'd0};
    // Compare the saturating poll count with the timeout before each poll CMD55.
    assign timed_out = (32'(ticks_reg) >= 32'(timeout_reg));
    // The first poll starts from a cleared count, so only a zero timeout expires.
    assign zero_timeout = (timeout_reg == 24'd0);

    sdinit_csd u_csd (
        .w1     (resp_word1),
        .w2     (resp_word2),
        .w3     (resp_word3),
        .blocks (csd_blocks)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 24'd1000;
            retry_reg   <= 3'd3;
            ocr_reg     <= 24'hFF8000;
            blklen_reg  <= 12'd512;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[23:0];
                REG_RETRY:   retry_reg   <= cfg_data[2:0];
                REG_OCR:     ocr_reg     <= cfg_data[23:0];
                REG_BLKLEN:  blklen_reg  <= cfg_data[11:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    // Next-state logic
    always_comb
    begin
        phase_next   = phase_reg;
        attempt_next = attempt_reg;
        v2_next      = v2_reg;
        hc_next      = hc_reg;
        rca_next     = rca_reg;
        ticks_next   = ticks_reg;
        cap_next     = cap_reg;
        mfr_next     = mfr_reg;
        serial_next  = serial_reg;
        date_next    = date_reg;
        if (opcode == OP_START)
        begin
            attempt_next = card_present ? 3'd1 : 3'd0;
            v2_next      = 1'b0;
            hc_next      = 1'b0;
            rca_next     = 16'd0;
            ticks_next   = '0;
            cap_next     = '0;
            mfr_next     = '0;
            serial_next  = '0;
            date_next    = '0;
            phase_next   = card_present ? PH_CMD0 : PH_IDLE;
        end
        else if (opcode == OP_TICK)
        begin
            if ((phase_reg == PH_P55 || phase_reg == PH_A41) && !(&ticks_reg))
            begin
                ticks_next = ticks_reg + 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: phase_next = PH_IDLE;
                PH_CMD0:
                begin
                    if (ok)
                    begin
                        attempt_next = 3'd1;
                        phase_next   = PH_CMD8;
                    end
                    else if (attempt_reg < retry_reg)
                    begin
                        attempt_next = attempt_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_CMD8:
                begin
                    if (ok && resp_word0[7:0] != 8'hAA)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (!ok && attempt_reg < retry_reg)
                    begin
                        attempt_next = attempt_reg + 3'd1;
                    end
                    else
                    begin
                        v2_next    = ok;
                        ticks_next = '0;
                        phase_next = zero_timeout ? PH_IDLE : PH_P55;
                    end
                end
                PH_P55: phase_next = ok ? PH_A41 : PH_IDLE;
                PH_A41:
                begin
                    if (!ok)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (resp_word0[31])
                    begin
                        hc_next    = v2_reg & resp_word0[30];
                        phase_next = PH_CMD2;
                    end
                    else
                    begin
                        phase_next = timed_out ? PH_IDLE : PH_P55;
                    end
                end
                PH_CMD2:
                begin
                    if (ok)
                    begin
                        mfr_next    = resp_word3[23:16];
                        serial_next = {resp_word1[15:0], resp_word0[31:16]};
                        date_next   = resp_word0[11:0];
                    end
                    phase_next = ok ? PH_CMD3 : PH_IDLE;
                end
                PH_CMD3:
                begin
                    if (ok)
                    begin
                        rca_next = resp_word0[31:16];
                    end
                    phase_next = ok ? PH_CMD9 : PH_IDLE;
                end
                PH_CMD9:
                begin
                    if (ok)
                    begin
                        cap_next = csd_blocks;
                    end
                    phase_next = ok ? PH_CMD7 : PH_IDLE;
                end
                PH_CMD7:
                begin
                    if (!ok)
                        phase_next = PH_IDLE;
                    else
                        phase_next = hc_reg ? PH_B55 : PH_CMD16;
                end
                PH_CMD16: phase_next = ok ? PH_B55 : PH_IDLE;
                PH_B55:   phase_next = ok ? PH_A6 : PH_IDLE;
                PH_A6:    phase_next = ok ? PH_HOST : PH_IDLE;
                PH_HOST:  phase_next = PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // Result logic
    always_comb
    begin
        res_next = '0;
        emit     = 1'b1;
        if (opcode == OP_START)
        begin
            if (!card_present)
            begin
                res_next.kind = RK_FAIL;
                res_next.err  = ERR_NOCARD;
            end
            else
            begin
                res_next.rtype = RT_NONE;
            end
        end
        else if (opcode == OP_TICK)
        begin
            emit = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: emit = 1'b0;
                PH_CMD0:
                begin
                    if (ok)
                    begin
                        res_next.index = 6'd8;
                        res_next.arg   = 32'h1AA;
                        res_next.rtype = RT_R6R7;
                    end
                    else if (!(attempt_reg < retry_reg))
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_CMD0;
                    end
                end
                PH_CMD8:
                begin
                    if (ok && resp_word0[7:0] != 8'hAA)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_ECHO;
                    end
                    else if (!ok && attempt_reg < retry_reg)
                    begin
                        res_next.index = 6'd8;
                        res_next.arg   = 32'h1AA;
                        res_next.rtype = RT_R6R7;
                    end
                    else if (zero_timeout)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_TMO;
                    end
                    else
                    begin
                        res_next.index = 6'd55;
                        res_next.arg   = rca_arg;
                        res_next.rtype = RT_R1;
                    end
                end
                PH_P55:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_A41;
                    end
                    else
                    begin
                        res_next.index = 6'd41;
                        res_next.arg   = {1'b0, v2_reg, 6'd0, ocr_reg};
                        res_next.rtype = RT_R3;
                    end
                end
                PH_A41:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_A41;
                    end
                    else if (resp_word0[31])
                    begin
                        res_next.index = 6'd2;
                        res_next.rtype = RT_R2;
                    end
                    else if (timed_out)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_TMO;
                    end
                    else
                    begin
                        res_next.index = 6'd55;
                        res_next.arg   = rca_arg;
                        res_next.rtype = RT_R1;
                    end
                end
                PH_CMD2:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_CMD2;
                    end
                    else
                    begin
                        res_next.index = 6'd3;
                        res_next.rtype = RT_R6R7;
                    end
                end
                PH_CMD3:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_CMD3;
                    end
                    else
                    begin
                        res_next.index = 6'd9;
                        res_next.arg   = {resp_word0[31:16], 16'd0};
                        res_next.rtype = RT_R2;
                    end
                end
                PH_CMD9:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_CMD9;
                    end
                    else
                    begin
                        res_next.index = 6'd7;
                        res_next.arg   = rca_arg;
                        res_next.rtype = RT_R1B;
                    end
                end
                PH_CMD7:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_CMD7;
                    end
                    else if (!hc_reg)
                    begin
                        res_next.index = 6'd16;
                        res_next.arg   = {20'd0, blklen_reg};
                        res_next.rtype = RT_R1;
                    end
                    else
                    begin
                        res_next.index = 6'd55;
                        res_next.arg   = rca_arg;
                        res_next.rtype = RT_R1;
                    end
                end
                PH_CMD16:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_CMD16;
                    end
                    else
                    begin
                        res_next.index = 6'd55;
                        res_next.arg   = rca_arg;
                        res_next.rtype = RT_R1;
                    end
                end
                PH_B55:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_BUS;
                    end
                    else
                    begin
                        res_next.index = 6'd6;
                        res_next.arg   = 32'h2;
                        res_next.rtype = RT_R1;
                    end
                end
                PH_A6:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_BUS;
                    end
                    else
                    begin
                        res_next.kind = RK_HOST;
                    end
                end
                PH_HOST:
                begin
                    if (!ok)
                    begin
                        res_next.kind = RK_FAIL;
                        res_next.err  = ERR_BUS;
                    end
                    else
                    begin
                        res_next.kind   = RK_DONE;
                        res_next.ctype  = !hc_reg ? 2'd0 :
                                          (cap_reg > SDHC_MAX_BLOCKS) ? 2'd2 : 2'd1;
                        res_next.cap    = cap_reg;
                        res_next.rca    = rca_reg;
                        res_next.mfr    = mfr_reg;
                        res_next.serial = serial_reg;
                        res_next.year   = 12'd2000 + 12'(date_reg[11:4]);
                        res_next.month  = date_reg[3:0];
                    end
                end
                default: emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            attempt_reg <= '0;
            v2_reg      <= 1'b0;
            hc_reg      <= 1'b0;
            rca_reg     <= '0;
            ticks_reg   <= '0;
            cap_reg     <= '0;
            mfr_reg     <= '0;
            serial_reg  <= '0;
            date_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                attempt_reg <= attempt_next;
                v2_reg      <= v2_next;
                hc_reg      <= hc_next;
                rca_reg     <= rca_next;
                ticks_reg   <= ticks_next;
                cap_reg     <= cap_next;
                mfr_reg     <= mfr_next;
                serial_reg  <= serial_next;
                date_reg    <= date_next;
            end
            // Drop the word once taken; load a new one on an emitting event.
            if (accept)
                ovalid_reg <= emit;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign out_valid    = ovalid_reg;
    assign result_kind  = res_reg.kind;
    assign cmd_index    = res_reg.index;
    assign cmd_arg      = res_reg.arg;
    assign resp_type    = res_reg.rtype;
    assign error_code   = res_reg.err;
    assign card_type    = res_reg.ctype;
    assign card_blocks  = res_reg.cap;
    assign card_address = res_reg.rca;
    assign maker_code   = res_reg.mfr;
    assign card_serial  = res_reg.serial;
    assign made_year    = res_reg.year;
    assign made_month   = res_reg.month;

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && out_stall |=> ovalid_reg && $stable(res_reg))
        else $error("result word changed under stall");
    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_TICK |=> !ovalid_reg)
        else $error("tick produced a result");
    a_fail_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && res_next.kind == RK_FAIL |=> phase_reg == PH_IDLE)
        else $error("failure left sequencer busy");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_IDLE && opcode != OP_START |=> !ovalid_reg)
        else $error("idle event produced a result");
`endif
endmodule

// ===== sim/sd_card_init_sequencer_tb.sv =====
// Self-checking testbench for the SD card identification sequencer.
module sd_card_init_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdinit_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_SET  = 280;

    // Card-side state as the sequencer should hold it.
    typedef struct {
        phase_t      ph;
        logic [2:0]  tries;
        logic        v2;
        logic        hc;
        logic [15:0] rca;
        logic [23:0] ticks;
        logic [32:0] cap;
        logic [7:0]  mfr;
        logic [31:0] serial;
        logic [11:0] date;
    } card_state_t;

    // One row of the directed sequence; exp is typed only where has_exp is set.
    typedef struct {
        logic [1:0]  op;
        logic        present;
        logic [31:0] w0, w1, w2, w3;
        logic        has_exp;
        result_t     exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_TICK;
    logic        card_present = 1'b0;
    logic [31:0] resp_word0 = '0;
    logic [31:0] resp_word1 = '0;
    logic [31:0] resp_word2 = '0;
    logic [31:0] resp_word3 = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [2:0]  resp_type;
    logic [3:0]  error_code;
    logic [1:0]  card_type;
    logic [32:0] card_blocks;
    logic [15:0] card_address;
    logic [7:0]  maker_code;
    logic [31:0] card_serial;
    logic [11:0] made_year;
    logic [3:0]  made_month;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_TIMEOUT;
    logic [31:0] cfg_data = '0;

    // Register copies shared by the stimulus shaper and the checker; they
    // change only while the block is idle.
    logic [23:0] poll_limit;
    logic [2:0]  try_limit;
    logic [23:0] ocr_window;
    logic [11:0] blk_len;

    card_state_t shaper_state;   // advanced as words are generated
    card_state_t checker_state;  // advanced as words are accepted
    result_t     pending_results[$];
    stim_row_t   stim_rows[$];

    int errors = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int identified = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;

    sd_card_init_sequencer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .card_present(card_present),
        .resp_word0(resp_word0), .resp_word1(resp_word1),
        .resp_word2(resp_word2), .resp_word3(resp_word3),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .cmd_index(cmd_index), .cmd_arg(cmd_arg),
        .resp_type(resp_type), .error_code(error_code), .card_type(card_type),
        .card_blocks(card_blocks), .card_address(card_address),
        .maker_code(maker_code), .card_serial(card_serial),
        .made_year(made_year), .made_month(made_month),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic card_state_t cleared_card();
        card_state_t s;
        s.ph = PH_IDLE; s.tries = '0; s.v2 = 1'b0; s.hc = 1'b0; s.rca = '0;
        s.ticks = '0; s.cap = '0; s.mfr = '0; s.serial = '0; s.date = '0;
        return s;
    endfunction

    function automatic result_t cmd_word(logic [5:0] idx, logic [31:0] arg, logic [2:0] rt);
        result_t r;
        r = '0;
        r.kind = RK_CMD; r.index = idx; r.arg = arg; r.rtype = rt;
        return r;
    endfunction

    function automatic result_t fail_word(logic [3:0] code);
        result_t r;
        r = '0;
        r.kind = RK_FAIL; r.err = code;
        return r;
    endfunction

    // Next ACMD41 poll step: give up once the tick count reaches the limit.
    function automatic bit next_poll(inout card_state_t s, output result_t r);
        if (s.ticks >= poll_limit)
        begin
            s.ph = PH_IDLE;
            r = fail_word(ERR_TMO);
        end
        else
        begin
            s.ph = PH_P55;
            r = cmd_word(6'd55, {s.rca, 16'h0}, RT_R1);
        end
        return 1'b1;
    endfunction

    // Advance the sequencer by one event word; return 1 when it emits a result.
    function automatic bit advance_card(inout card_state_t s, input logic [1:0] op,
                                        input logic present, input logic [31:0] w0,
                                        input logic [31:0] w1, input logic [31:0] w2,
                                        input logic [31:0] w3, output result_t r);
        logic        ok;
        logic [31:0] rca_arg;
        logic [11:0] csize;
        logic [63:0] bytes;
        ok = (op == OP_OK);
        rca_arg = {s.rca, 16'h0};
        r = '0;
        if (op == OP_START)
        begin
            s = cleared_card();
            if (!present)
            begin
                r = fail_word(ERR_NOCARD);
                return 1'b1;
            end
            s.tries = 3'd1;
            s.ph = PH_CMD0;
            r = cmd_word(6'd0, 32'h0, RT_NONE);
            return 1'b1;
        end
        if (op == OP_TICK)
        begin
            if ((s.ph == PH_P55 || s.ph == PH_A41) && s.ticks != '1)
                s.ticks = s.ticks + 1'b1;
            return 1'b0;
        end
        if (s.ph != PH_IDLE && s.ph != PH_CMD0 && s.ph != PH_CMD8 && !ok)
        begin
            // Any failure past CMD8 ends the run with the step's own code.
            case (s.ph)
                PH_P55, PH_A41: r = fail_word(ERR_A41);
                PH_CMD2:        r = fail_word(ERR_CMD2);
                PH_CMD3:        r = fail_word(ERR_CMD3);
                PH_CMD9:        r = fail_word(ERR_CMD9);
                PH_CMD7:        r = fail_word(ERR_CMD7);
                PH_CMD16:       r = fail_word(ERR_CMD16);
                default:        r = fail_word(ERR_BUS);
            endcase
            s.ph = PH_IDLE;
            return 1'b1;
        end
        case (s.ph)
            PH_CMD0:
            begin
                if (ok)
                begin
                    s.tries = 3'd1;
                    s.ph = PH_CMD8;
                    r = cmd_word(6'd8, 32'h1AA, RT_R6R7);
                end
                else if (s.tries < try_limit)
                begin
                    s.tries = s.tries + 1'b1;
                    r = cmd_word(6'd0, 32'h0, RT_NONE);
                end
                else
                begin
                    s.ph = PH_IDLE;
                    r = fail_word(ERR_CMD0);
                end
                return 1'b1;
            end
            PH_CMD8:
            begin
                if (ok)
                begin
                    if (w0[7:0] != 8'hAA)
                    begin
                        s.ph = PH_IDLE;
                        r = fail_word(ERR_ECHO);
                        return 1'b1;
                    end
                    s.v2 = 1'b1;
                end
                else if (s.tries < try_limit)
                begin
                    s.tries = s.tries + 1'b1;
                    r = cmd_word(6'd8, 32'h1AA, RT_R6R7);
                    return 1'b1;
                end
                else
                    s.v2 = 1'b0;   // no answer to CMD8: treat as a v1 card
                s.ticks = '0;
                return next_poll(s, r);
            end
            PH_P55:
            begin
                s.ph = PH_A41;
                r = cmd_word(6'd41, {8'h0, ocr_window} | {1'b0, s.v2, 30'h0}, RT_R3);
                return 1'b1;
            end
            PH_A41:
            begin
                if (!w0[31])
                    return next_poll(s, r);
                s.hc = s.v2 & w0[30];
                s.ph = PH_CMD2;
                r = cmd_word(6'd2, 32'h0, RT_R2);
                return 1'b1;
            end
            PH_CMD2:
            begin
                s.mfr = w3[23:16];
                s.serial = {w1[15:0], w0[31:16]};
                s.date = w0[11:0];
                s.ph = PH_CMD3;
                r = cmd_word(6'd3, 32'h0, RT_R6R7);
                return 1'b1;
            end
            PH_CMD3:
            begin
                s.rca = w0[31:16];
                s.ph = PH_CMD9;
                r = cmd_word(6'd9, {w0[31:16], 16'h0}, RT_R2);
                return 1'b1;
            end
            PH_CMD9:
            begin
                if (w3[23:22] == 2'd0)
                begin
                    // v1 CSD: (size+1) << (size multiplier+2) << block length exponent
                    csize = {w2[1:0], w1[31:22]};
                    bytes = (64'(csize) + 64'd1) << (5'(w1[9:7]) + 5'd2);
                    bytes = bytes << w2[11:8];
                    s.cap = bytes[41:9];
                end
                else
                    s.cap = (33'(w1[29:8]) + 33'd1) * 33'd1024;
                s.ph = PH_CMD7;
                r = cmd_word(6'd7, rca_arg, RT_R1B);
                return 1'b1;
            end
            PH_CMD7:
            begin
                if (!s.hc)
                begin
                    s.ph = PH_CMD16;
                    r = cmd_word(6'd16, {20'h0, blk_len}, RT_R1);
                end
                else
                begin
                    s.ph = PH_B55;
                    r = cmd_word(6'd55, rca_arg, RT_R1);
                end
                return 1'b1;
            end
            PH_CMD16:
            begin
                s.ph = PH_B55;
                r = cmd_word(6'd55, rca_arg, RT_R1);
                return 1'b1;
            end
            PH_B55:
            begin
                s.ph = PH_A6;
                r = cmd_word(6'd6, 32'h2, RT_R1);
                return 1'b1;
            end
            PH_A6:
            begin
                s.ph = PH_HOST;
                r.kind = RK_HOST;
                return 1'b1;
            end
            PH_HOST:
            begin
                s.ph = PH_IDLE;
                r.kind = RK_DONE;
                r.ctype = !s.hc ? 2'd0 : (s.cap > SDHC_MAX_BLOCKS ? 2'd2 : 2'd1);
                r.cap = s.cap;
                r.rca = s.rca;
                r.mfr = s.mfr;
                r.serial = s.serial;
                r.year = 12'd2000 + 12'(s.date[11:4]);
                r.month = s.date[3:0];
                return 1'b1;
            end
            default:
            begin
                s.ph = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic compare_result(result_t e, result_t a);
        report_field("result_kind", e.kind, a.kind);
        report_field("cmd_index", e.index, a.index);
        report_field("cmd_arg", e.arg, a.arg);
        report_field("resp_type", e.rtype, a.rtype);
        report_field("error_code", e.err, a.err);
        report_field("card_type", e.ctype, a.ctype);
        report_field("card_blocks", e.cap, a.cap);
        report_field("card_address", e.rca, a.rca);
        report_field("maker_code", e.mfr, a.mfr);
        report_field("card_serial", e.serial, a.serial);
        report_field("made_year", e.year, a.year);
        report_field("made_month", e.month, a.month);
    endtask

    // Monitor: check each result word against the oldest expectation, then
    // predict from the event word accepted at this edge.
    always @(posedge clk)
    begin
        result_t got, want, next_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{result_kind, cmd_index, cmd_arg, resp_type, error_code, card_type,
                        card_blocks, card_address, maker_code, card_serial,
                        made_year, made_month};
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result word with nothing expected, kind %0d",
                             $time, result_kind);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_result(want, got);
                    if (want.kind == RK_DONE)
                        identified++;
                end
            end
            if (in_valid && !in_stall)
            begin
                words_accepted++;
                if (advance_card(checker_state, opcode, card_present, resp_word0,
                                 resp_word1, resp_word2, resp_word3, next_r))
                    pending_results.push_back(next_r);
            end
        end
    end

    // Watchdog: end the run if no handshake completes for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("sd_card_init_sequencer_tb failed");
            $finish;
        end
    end

    // Receiver: stall in stretches of random density, plus one long hold-off
    // on request so the output register fills and backs up the input.
    initial
    begin
        int stretch;
        int pct;
        stretch = 0;
        pct = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    stretch = $urandom_range(80, 10);
                    case ($urandom_range(2))
                        0: pct = 0;
                        1: pct = 20;
                        default: pct = 60;
                    endcase
                end
                stretch--;
                out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    // Offer one event word and hold it until accepted; idle between bursts.
    // Called at a rising edge, returns at the edge where the word is taken.
    task automatic send_word(logic [1:0] op, logic present, logic [31:0] w0,
                             logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(20, 1);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode <= op;
        card_present <= present;
        resp_word0 <= w0;
        resp_word1 <= w1;
        resp_word2 <= w2;
        resp_word3 <= w3;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid, then wait out every expected result and the pipeline.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Offer one register write and return at the edge where it is taken;
    // the caller drops valid after the last write of a group.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
        case (idx)
            REG_TIMEOUT: poll_limit = val[23:0];
            REG_RETRY:   try_limit = val[2:0];
            REG_OCR:     ocr_window = val[23:0];
            default:     blk_len = val[11:0];
        endcase
    endtask

    // Write all four registers; upper data bits carry noise the block drops.
    task automatic load_regs(logic [23:0] tmo, logic [2:0] tries, logic [23:0] ocr,
                             logic [11:0] blen);
        write_reg(REG_TIMEOUT, {8'($urandom_range(255)), tmo});
        write_reg(REG_RETRY, ($urandom & 32'hFFFF_FFF8) | 32'(tries));
        write_reg(REG_OCR, {8'($urandom_range(255)), ocr});
        write_reg(REG_BLKLEN, ($urandom & 32'hFFFF_F000) | 32'(blen));
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(logic [1:0] op, logic present, logic [31:0] w0,
                                    logic [31:0] w1, logic [31:0] w2, logic [31:0] w3,
                                    logic has_exp, result_t exp_r);
        stim_row_t row;
        row.op = op; row.present = present;
        row.w0 = w0; row.w1 = w1; row.w2 = w2; row.w3 = w3;
        row.has_exp = has_exp; row.exp = exp_r;
        stim_rows.push_back(row);
    endfunction

    // Random event word shaped by where the sequence stands: mostly ok with
    // plausible response content, some failures, ticks while polling.
    task automatic random_word(output int counted);
        logic [1:0]  op;
        logic        present;
        logic [31:0] w0, w1, w2, w3;
        result_t     dummy;
        int          roll;
        w0 = $urandom; w1 = $urandom; w2 = $urandom; w3 = $urandom;
        present = ($urandom_range(19) != 0);
        roll = $urandom_range(99);
        if (shaper_state.ph == PH_IDLE)
            op = (roll < 85) ? OP_START : 2'($urandom_range(3, 1));
        else if (roll < 2)
            op = OP_START;
        else if ((shaper_state.ph == PH_P55 || shaper_state.ph == PH_A41) && roll < 35)
            op = OP_TICK;
        else if (roll < 8)
            op = OP_TICK;
        else if (roll < 15)
            op = OP_FAIL;
        else
            op = OP_OK;
        case (shaper_state.ph)
            PH_CMD8: if ($urandom_range(9) != 0) w0[7:0] = 8'hAA;
            PH_A41:  w0[31] = ($urandom_range(9) < 4);
            PH_CMD9: if ($urandom_range(1) == 0) w3[23:22] = 2'd0;
            default: ;
        endcase
        counted = !(op == OP_TICK && shaper_state.ph != PH_P55 && shaper_state.ph != PH_A41)
                  && !(shaper_state.ph == PH_IDLE && op != OP_START);
        void'(advance_card(shaper_state, op, present, w0, w1, w2, w3, dummy));
        send_word(op, present, w0, w1, w2, w3);
    endtask

    initial
    begin
        result_t predicted;
        result_t nothing;
        int      counted;
        int      taken;
        nothing = '0;
        poll_limit = 24'd1000;
        try_limit = 3'd3;
        ocr_window = 24'hFF8000;
        blk_len = 12'd512;
        shaper_state = cleared_card();
        checker_state = cleared_card();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values.
        add_row(OP_TICK, 1'b1, '0, '0, '0, '0, 1'b0, nothing);      // ignored while idle
        add_row(OP_OK, 1'b1, '1, '1, '1, '1, 1'b0, nothing);        // ignored while idle
        add_row(OP_START, 1'b0, '0, '0, '0, '0, 1'b1, fail_word(ERR_NOCARD));
        add_row(OP_START, 1'b1, '0, '0, '0, '0, 1'b1, cmd_word(6'd0, 32'h0, RT_NONE));
        add_row(OP_FAIL, 1'b1, '0, '0, '0, '0, 1'b1, cmd_word(6'd0, 32'h0, RT_NONE));
        add_row(OP_FAIL, 1'b1, '0, '0, '0, '0, 1'b1, cmd_word(6'd0, 32'h0, RT_NONE));
        add_row(OP_FAIL, 1'b1, '0, '0, '0, '0, 1'b1, fail_word(ERR_CMD0));
        add_row(OP_START, 1'b1, '1, '1, '1, '1, 1'b0, nothing);
        add_row(OP_OK, 1'b1, '0, '0, '0, '0, 1'b1, cmd_word(6'd8, 32'h1AA, RT_R6R7));
        add_row(OP_OK, 1'b1, 32'h55, '0, '0, '0, 1'b1, fail_word(ERR_ECHO));
        // Full run of a v1 card: CMD8 never answers, so CMD16 is sent.
        add_row(OP_START, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_OK, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_FAIL, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_FAIL, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_FAIL, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_OK, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_TICK, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_OK, 1'b1, 32'h0, '0, '0, '0, 1'b0, nothing);     // card busy, poll again
        add_row(OP_OK, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_OK, 1'b1, 32'hC000_0000, '0, '0, '0, 1'b0, nothing);
        add_row(OP_OK, 1'b1, '1, '1, '1, '1, 1'b0, nothing);        // CID all ones
        add_row(OP_OK, 1'b1, 32'hFFFF_0000, '0, '0, '0, 1'b0, nothing);
        add_row(OP_OK, 1'b1, '1, '1, '1, 32'h0, 1'b0, nothing);     // largest v1 CSD
        add_row(OP_OK, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        add_row(OP_OK, 1'b1, '0, '0, '0, '0, 1'b0, nothing);
        foreach (stim_rows[i])
        begin
            void'(advance_card(shaper_state, stim_rows[i].op, stim_rows[i].present,
                               stim_rows[i].w0, stim_rows[i].w1, stim_rows[i].w2,
                               stim_rows[i].w3, predicted));
            if (stim_rows[i].has_exp && predicted !== stim_rows[i].exp)
            begin
                errors++;
                $display("%0t ns: row %0d expected 0x%0h, predictor gave 0x%0h",
                         $time, i, stim_rows[i].exp, predicted);
            end
            send_word(stim_rows[i].op, stim_rows[i].present, stim_rows[i].w0,
                      stim_rows[i].w1, stim_rows[i].w2, stim_rows[i].w3);
        end
        // Finish the v1 run through CMD55, ACMD6, host switch and success.
        while (shaper_state.ph != PH_IDLE)
        begin
            void'(advance_card(shaper_state, OP_OK, 1'b1, '0, '0, '0, '0, predicted));
            send_word(OP_OK, 1'b1, '0, '0, '0, '0);
        end

        // Random part over several register settings, extremes first.
        for (int set_no = 0; set_no < 6; set_no++)
        begin
            wait_quiet();
            case (set_no)
                0: load_regs(24'd0, 3'd0, 24'd0, 12'd0);
                1: load_regs(24'hFFFFFF, 3'd7, 24'hFFFFFF, 12'hFFF);
                2: load_regs(24'd1, 3'd1, 24'($urandom), 12'd2048);
                default: load_regs(24'($urandom_range(40)), 3'($urandom_range(7)),
                                   24'($urandom), 12'($urandom));
            endcase
            taken = 0;
            while (taken < ITEMS_PER_SET || shaper_state.ph != PH_IDLE)
            begin
                if (set_no == 3 && taken == 100)
                    hold_req = 1'b1;   // receiver backs off while words keep coming
                random_word(counted);
                taken += counted;
            end
        end

        wait_quiet();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            errors++;
        $display("Covered %0d event words, %0d result words checked, %0d cards identified,",
                 words_accepted, results_checked, identified);
        $display("%0d register writes over six settings, with one long output hold-off.",
                 reg_writes);
        if (errors == 0)
            $display("sd_card_init_sequencer_tb passed");
        else
            $display("sd_card_init_sequencer_tb failed");
        $finish;
    end
endmodule
